FILE: rtl/sstc_pkg.sv
// ----------------------------------------------------------------------------
// sstc_pkg: shared types and constants of the slot table
// Field widths, operation and status codes, and the control bundle that
// the sequencer hands to the slot storage.
// ----------------------------------------------------------------------------
package sstc_pkg;

	localparam int MODE_W   = 3;
	localparam int VALUE_W  = 32;
	localparam int SLOT_W   = 10;
	localparam int LEN_W    = 11;
	localparam int STATUS_W = 2;

	// Compaction runs when holes reach a tenth of the length: 100*h/L >= 10
	// is the same test as HOLE_RATIO*h >= L.
	localparam int HOLE_RATIO = 10;

	localparam logic [MODE_W-1:0] MODE_ADD     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_RESERVE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_COMPACT = 3'd3;
	localparam logic [MODE_W-1:0] MODE_TRUNC   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_SETMIN  = 3'd5;

	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_INVAL   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOSPACE = 2'd2;

	typedef struct packed {
		logic rd_en;
		logic flag_we;
		logic flag_wd;
		logic val_we;
		logic hwm_we;
	} tbl_ctl_t;

endpackage

FILE: rtl/sstc_table.sv
// ----------------------------------------------------------------------------
// sstc_table: slot flag and value storage
// One read port with registered data and one write port per array. Flags
// at or above one past the highest flag ever written read as zero, so the
// flag array needs no clearing after reset.
// ----------------------------------------------------------------------------
module sstc_table #(
	parameter int CAPACITY    = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sstc_pkg::tbl_ctl_t             ctl,
	input  logic [$clog2(CAPACITY)-1:0]    rd_addr,
	input  logic [$clog2(CAPACITY)-1:0]    flag_addr,
	input  logic [$clog2(CAPACITY)-1:0]    val_addr,
	input  logic [VALUE_WIDTH-1:0]         val_wd,
	input  logic [$clog2(CAPACITY+1)-1:0]  hwm_len,
	output logic                           rd_flag,
	output logic [VALUE_WIDTH-1:0]         rd_val
);

	localparam int IW = $clog2(CAPACITY);
	localparam int LW = $clog2(CAPACITY + 1);

	logic                   flag_mem [CAPACITY];
	logic [VALUE_WIDTH-1:0] val_mem  [CAPACITY];

	logic                   raw_flag_q;
	logic [VALUE_WIDTH-1:0] rd_val_q;
	logic [IW-1:0]          rd_idx_q;
	logic [LW-1:0]          hwm_q;

	always_ff @(posedge clk) begin
		if (ctl.flag_we) begin
			flag_mem[flag_addr] <= ctl.flag_wd;
		end
		if (ctl.val_we) begin
			val_mem[val_addr] <= val_wd;
		end
		if (ctl.rd_en) begin
			raw_flag_q <= flag_mem[rd_addr];
			rd_val_q   <= val_mem[rd_addr];
			rd_idx_q   <= rd_addr;
		end
	end

	// Entries at or above the high-water mark have never had their flag set or their value written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hwm_q <= '0;
		end else if (ctl.hwm_we && (hwm_len > hwm_q)) begin
			hwm_q <= hwm_len;
		end
	end

	assign rd_flag = raw_flag_q & (LW'(rd_idx_q) < hwm_q);
	assign rd_val  = rd_val_q;

endmodule

FILE: rtl/sparse_slot_table_with_compaction.sv
// ----------------------------------------------------------------------------
// sparse_slot_table_with_compaction: slot allocator with compaction
// Operations that touch no slot (errors, set minimum, growing truncate,
// appending add, compaction below threshold) go straight to the result
// state; a remove reads its slot first; find-free, shrinking truncate and
// compaction walk the slots one flag read per cycle.
// One transaction is in work at a time; the result register frees the input.
// Reset clears the control state at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sparse_slot_table_with_compaction #(
	parameter int CAPACITY    = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  logic [sstc_pkg::MODE_W-1:0]     mode,
	input  logic [sstc_pkg::VALUE_W-1:0]    value,
	input  logic [sstc_pkg::SLOT_W-1:0]     slot_index,
	input  logic [sstc_pkg::LEN_W-1:0]      new_length,
	input  logic                            force_req,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output logic [sstc_pkg::STATUS_W-1:0]   status,
	output logic [sstc_pkg::SLOT_W-1:0]     slot,
	output logic [sstc_pkg::LEN_W-1:0]      length_now,
	output logic [sstc_pkg::LEN_W-1:0]      used_now
);

	localparam int IW = $clog2(CAPACITY);
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int CW = (LW > sstc_pkg::LEN_W) ? LW : sstc_pkg::LEN_W;
	localparam int TW = LW + 4;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_RESP = 2'd2;

	logic [1:0]                     state_q, state_d;
	logic [sstc_pkg::MODE_W-1:0]    op_q, op_d;
	logic [VALUE_WIDTH-1:0]         val_q, val_d;
	logic [LW-1:0]                  rd_q, rd_d;
	logic [LW-1:0]                  end_q, end_d;
	logic [LW-1:0]                  tgt_q, tgt_d;
	logic [LW-1:0]                  dst_q, dst_d;
	logic [LW-1:0]                  len_q, len_d;
	logic [LW-1:0]                  used_q, used_d;
	logic [LW-1:0]                  min_q, min_d;
	logic [sstc_pkg::STATUS_W-1:0]  res_status_q, res_status_d;
	logic [sstc_pkg::SLOT_W-1:0]    res_slot_q, res_slot_d;
	logic                           pend_s1;
	logic [LW-1:0]                  idx_s1;
	logic                           rsp_valid_q;
	logic [sstc_pkg::STATUS_W-1:0]  rsp_status_q;
	logic [sstc_pkg::SLOT_W-1:0]    rsp_slot_q;
	logic [sstc_pkg::LEN_W-1:0]     rsp_len_q;
	logic [sstc_pkg::LEN_W-1:0]     rsp_used_q;

	sstc_pkg::tbl_ctl_t             ctl;
	logic [IW-1:0]                  flag_addr;
	logic [IW-1:0]                  val_addr;
	logic [VALUE_WIDTH-1:0]         val_wd;
	logic [LW-1:0]                  hwm_len;
	logic                           rd_flag;
	logic [VALUE_WIDTH-1:0]         rd_val;
	logic                           issue;
	logic                           done;
	logic                           rsp_load;

	logic [CW-1:0]                  len_x, used_x, min_x, nl_x, cap_x;
	logic [LW-1:0]                  holes;
	logic [TW-1:0]                  ten_holes;
	logic                           compact_run;

	assign len_x  = CW'(len_q);
	assign used_x = CW'(used_q);
	assign min_x  = CW'(min_q);
	assign nl_x   = CW'(new_length);
	assign cap_x  = CW'(CAPACITY);

	assign holes       = len_q - used_q;
	assign ten_holes   = TW'(holes) * TW'(sstc_pkg::HOLE_RATIO);
	assign compact_run = (ten_holes >= TW'(len_q)) || (force_req && (holes != '0));

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_load  = (state_q == ST_RESP) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		state_d      = state_q;
		op_d         = op_q;
		val_d        = val_q;
		rd_d         = rd_q;
		end_d        = end_q;
		tgt_d        = tgt_q;
		dst_d        = dst_q;
		len_d        = len_q;
		used_d       = used_q;
		min_d        = min_q;
		res_status_d = res_status_q;
		res_slot_d   = res_slot_q;
		ctl          = '0;
		flag_addr    = '0;
		val_addr     = '0;
		val_wd       = val_q;
		hwm_len      = len_q;
		issue        = 1'b0;
		done         = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					op_d         = mode;
					val_d        = VALUE_WIDTH'(value);
					res_status_d = sstc_pkg::STATUS_OK;
					res_slot_d   = '0;
					tgt_d        = len_q;
					state_d      = ST_RESP;
					unique case (mode)
						sstc_pkg::MODE_ADD, sstc_pkg::MODE_RESERVE: begin
							if (used_x >= len_x) begin
								if (len_x >= cap_x) begin
									res_status_d = sstc_pkg::STATUS_NOSPACE;
								end else begin
									// No hole: the new slot is appended at the end.
									res_slot_d  = sstc_pkg::SLOT_W'(len_q);
									len_d       = len_q + 1'b1;
									if (mode == sstc_pkg::MODE_ADD) begin
										ctl.flag_we = 1'b1;
										ctl.flag_wd = 1'b1;
										flag_addr   = len_q[IW-1:0];
										ctl.hwm_we  = 1'b1;
										hwm_len     = len_q + 1'b1;
										ctl.val_we  = 1'b1;
										val_addr    = len_q[IW-1:0];
										val_wd      = VALUE_WIDTH'(value);
										used_d      = used_q + 1'b1;
									end
								end
							end else begin
								rd_d    = '0;
								end_d   = len_q;
								state_d = ST_SCAN;
							end
						end
						sstc_pkg::MODE_REMOVE: begin
							if (CW'(slot_index) >= len_x) begin
								res_status_d = sstc_pkg::STATUS_INVAL;
							end else begin
								rd_d    = LW'(slot_index);
								end_d   = LW'(slot_index) + 1'b1;
								state_d = ST_SCAN;
							end
						end
						sstc_pkg::MODE_COMPACT: begin
							if ((len_q != '0) && compact_run) begin
								rd_d    = '0;
								end_d   = len_q;
								dst_d   = '0;
								tgt_d   = (used_q > min_q) ? used_q : min_q;
								state_d = ST_SCAN;
							end
						end
						sstc_pkg::MODE_TRUNC: begin
							if (nl_x < min_x) begin
								res_status_d = sstc_pkg::STATUS_INVAL;
							end else if (nl_x > cap_x) begin
								res_status_d = sstc_pkg::STATUS_NOSPACE;
							end else if (nl_x < len_x) begin
								rd_d    = LW'(new_length);
								end_d   = len_q;
								tgt_d   = LW'(new_length);
								state_d = ST_SCAN;
							end else begin
								len_d = LW'(new_length);
							end
						end
						sstc_pkg::MODE_SETMIN: begin
							if (nl_x <= len_x) begin
								min_d = LW'(new_length);
							end else if (nl_x > cap_x) begin
								res_status_d = sstc_pkg::STATUS_NOSPACE;
							end else begin
								len_d = LW'(new_length);
								min_d = LW'(new_length);
							end
						end
						default: begin
							res_status_d = sstc_pkg::STATUS_INVAL;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (pend_s1) begin
					unique case (op_q)
						sstc_pkg::MODE_ADD, sstc_pkg::MODE_RESERVE: begin
							if (!rd_flag) begin
								res_slot_d = sstc_pkg::SLOT_W'(idx_s1);
								if (op_q == sstc_pkg::MODE_ADD) begin
									ctl.flag_we = 1'b1;
									ctl.flag_wd = 1'b1;
									flag_addr   = idx_s1[IW-1:0];
									ctl.hwm_we  = 1'b1;
									hwm_len     = idx_s1 + 1'b1;
									ctl.val_we  = 1'b1;
									val_addr    = idx_s1[IW-1:0];
									val_wd      = val_q;
									used_d      = used_q + 1'b1;
								end
								done    = 1'b1;
								state_d = ST_RESP;
							end
						end
						sstc_pkg::MODE_REMOVE: begin
							if (rd_flag) begin
								ctl.flag_we = 1'b1;
								ctl.flag_wd = 1'b0;
								flag_addr   = idx_s1[IW-1:0];
								used_d      = used_q - 1'b1;
							end
							done    = 1'b1;
							state_d = ST_RESP;
						end
						sstc_pkg::MODE_TRUNC: begin
							ctl.flag_we = 1'b1;
							ctl.flag_wd = 1'b0;
							flag_addr   = idx_s1[IW-1:0];
							if (rd_flag) begin
								used_d = used_q - 1'b1;
							end
						end
						sstc_pkg::MODE_COMPACT: begin
							// The used count is the final number of packed slots, so
							// every walked flag is rewritten to its final value here.
							ctl.flag_we = 1'b1;
							ctl.flag_wd = (idx_s1 < used_q);
							flag_addr   = idx_s1[IW-1:0];
							ctl.hwm_we  = 1'b1;
							hwm_len     = idx_s1 + 1'b1;
							if (rd_flag) begin
								if (dst_q != idx_s1) begin
									ctl.val_we = 1'b1;
									val_addr   = dst_q[IW-1:0];
									val_wd     = rd_val;
								end
								dst_d = dst_q + 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
				if (!done) begin
					if (rd_q < end_q) begin
						issue = 1'b1;
						rd_d  = rd_q + 1'b1;
					end else begin
						// The last read is evaluated in this cycle.
						len_d   = tgt_q;
						state_d = ST_RESP;
					end
				end
			end
			ST_RESP: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		ctl.rd_en = issue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_s1     <= 1'b0;
			len_q       <= '0;
			used_q      <= '0;
			min_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= issue;
			len_q   <= len_d;
			used_q  <= used_d;
			min_q   <= min_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q         <= op_d;
		val_q        <= val_d;
		rd_q         <= rd_d;
		end_q        <= end_d;
		tgt_q        <= tgt_d;
		dst_q        <= dst_d;
		res_status_q <= res_status_d;
		res_slot_q   <= res_slot_d;
		if (issue) begin
			idx_s1 <= rd_q;
		end
		if (rsp_load) begin
			rsp_status_q <= res_status_q;
			rsp_slot_q   <= res_slot_q;
			rsp_len_q    <= sstc_pkg::LEN_W'(len_q);
			rsp_used_q   <= sstc_pkg::LEN_W'(used_q);
		end
	end

	sstc_table #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.rd_addr   (rd_q[IW-1:0]),
		.flag_addr (flag_addr),
		.val_addr  (val_addr),
		.val_wd    (val_wd),
		.hwm_len   (hwm_len),
		.rd_flag   (rd_flag),
		.rd_val    (rd_val)
	);

	assign rsp_valid  = rsp_valid_q;
	assign status     = rsp_status_q;
	assign slot       = rsp_slot_q;
	assign length_now = rsp_len_q;
	assign used_now   = rsp_used_q;

endmodule
